FILE: src/stable_sorted_priority_queue_top_macros.svh
// assertion macros for the sorted priority queue
`ifndef STABLE_SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define SSPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SSPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/sspq_pkg.sv
// shared types and constants for the sorted priority queue
package sspq_pkg;

  localparam int CAPACITY       = 16;
  localparam int VALUE_WIDTH    = 32;
  localparam int PRIORITY_WIDTH = 16;
  localparam int CNT_W          = $clog2(CAPACITY + 1);

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef logic [VALUE_WIDTH-1:0]    value_t;
  typedef logic [PRIORITY_WIDTH-1:0] prio_t;
  typedef logic [CNT_W-1:0]          cnt_t;

  typedef enum logic [1:0] {
    CMD_ENQ   = 2'd0,
    CMD_DEQ   = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // broadcast to every cell of the row
  typedef struct packed {
    logic   enq;
    logic   deq;
    value_t new_value;
    prio_t  new_prio;
  } cell_ctl_t;

endpackage

FILE: src/sspq_if.sv
// request and result channel interfaces
interface sspq_in_if;
  import sspq_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  value_t      item_value;
  prio_t       item_priority;

  modport source (output valid, output cmd, output item_value, output item_priority,
                  input ready);
  modport sink   (input valid, input cmd, input item_value, input item_priority,
                  output ready);
endinterface

interface sspq_out_if;
  import sspq_pkg::*;
  logic        valid;
  logic        ready;
  status_t     status;
  logic        is_empty;
  cnt_t        entry_total;
  value_t      head_value;
  prio_t       head_priority;

  modport source (output valid, output status, output is_empty, output entry_total,
                  output head_value, output head_priority, input ready);
  modport sink   (input valid, input status, input is_empty, input entry_total,
                  input head_value, input head_priority, output ready);
endinterface

FILE: src/sspq_cell.sv
// one slot of the sorted row: holds an entry and shifts with its neighbors
module sspq_cell (
  input  logic               clk,
  input  sspq_pkg::cell_ctl_t ctl,
  input  logic               occ,
  input  logic               left_keep,
  output logic               keep,
  input  sspq_pkg::value_t   left_value,
  input  sspq_pkg::prio_t    left_prio,
  input  sspq_pkg::value_t   right_value,
  input  sspq_pkg::prio_t    right_prio,
  output sspq_pkg::value_t   value,
  output sspq_pkg::prio_t    prio
);
  import sspq_pkg::*;

  value_t val_r, val_nxt;
  prio_t  prio_r, prio_nxt;

  // entry stays put when it sorts at or before the new one
  assign keep  = occ && (prio_r <= ctl.new_prio);
  assign value = val_r;
  assign prio  = prio_r;

  always_comb begin
    val_nxt  = val_r;
    prio_nxt = prio_r;
    if (ctl.enq) begin
      if (!keep) begin
        if (left_keep) begin
          val_nxt  = ctl.new_value;
          prio_nxt = ctl.new_prio;
        end else begin
          val_nxt  = left_value;
          prio_nxt = left_prio;
        end
      end
    end else if (ctl.deq) begin
      val_nxt  = right_value;
      prio_nxt = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    prio_r <= prio_nxt;
  end

endmodule

FILE: src/stable_sorted_priority_queue_top.sv
// Sorted priority queue built as a row of shifting cells, head in cell 0.
// An accepted request updates the row at acceptance and is held as pending until
// the head is captured into the result register, which waits while the output
// holds a result not yet taken. No new request is accepted while one is pending.
// Reset (rst_n, synchronous): queue empty, no pending request, no result held;
// slot contents are not cleared and are never read before being written.
module stable_sorted_priority_queue_top (
  input logic       clk,
  input logic       rst_n,
  sspq_in_if.sink   in_req,
  sspq_out_if.source out_res
);
  import sspq_pkg::*;

  `include "stable_sorted_priority_queue_top_macros.svh"

  cnt_t      cnt_r, cnt_nxt;
  logic      pending_r;
  status_t   status_r, status_nxt;
  logic      out_valid_r;
  status_t   out_status_r;
  cnt_t      out_total_r;
  value_t    out_value_r;
  prio_t     out_prio_r;
  logic      accept;
  logic      out_load;
  cell_ctl_t ctl;

  value_t val_w  [CAPACITY];
  prio_t  prio_w [CAPACITY];
  logic   keep_w [CAPACITY];

  assign in_req.ready = !pending_r;
  assign accept       = in_req.valid && !pending_r;
  assign out_load     = pending_r && (!out_valid_r || out_res.ready);

  always_comb begin
    cnt_nxt        = cnt_r;
    status_nxt     = ST_OK;
    ctl.enq        = 1'b0;
    ctl.deq        = 1'b0;
    ctl.new_value  = in_req.item_value;
    ctl.new_prio   = in_req.item_priority;
    if (accept) begin
      unique case (in_req.cmd)
        CMD_ENQ: begin
          if (cnt_r == CAP_CNT) begin
            status_nxt = ST_FULL;
          end else begin
            ctl.enq = 1'b1;
            cnt_nxt = cnt_r + cnt_t'(1);
          end
        end
        CMD_DEQ: begin
          if (cnt_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            ctl.deq = 1'b1;
            cnt_nxt = cnt_r - cnt_t'(1);
          end
        end
        default: status_nxt = ST_OK;
      endcase
    end
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic   lk;
      value_t lv, rv;
      prio_t  lp, rp;
      if (g == 0) begin : g_first
        assign lk = 1'b1;
        assign lv = '0;
        assign lp = '0;
      end else begin : g_mid
        assign lk = keep_w[g-1];
        assign lv = val_w[g-1];
        assign lp = prio_w[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign rv = '0;
        assign rp = '0;
      end else begin : g_inner
        assign rv = val_w[g+1];
        assign rp = prio_w[g+1];
      end
      sspq_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .occ         (cnt_r > cnt_t'(g)),
        .left_keep   (lk),
        .keep        (keep_w[g]),
        .left_value  (lv),
        .left_prio   (lp),
        .right_value (rv),
        .right_prio  (rp),
        .value       (val_w[g]),
        .prio        (prio_w[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (accept) begin
        pending_r <= 1'b1;
      end else if (out_load) begin
        pending_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
    end
    if (out_load) begin
      out_status_r <= status_r;
      out_total_r  <= cnt_r;
      // head reads as zero when the queue is empty
      out_value_r  <= (cnt_r == '0) ? '0 : val_w[0];
      out_prio_r   <= (cnt_r == '0) ? '0 : prio_w[0];
    end
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.status        = out_status_r;
  assign out_res.is_empty      = (out_total_r == '0);
  assign out_res.entry_total   = out_total_r;
  assign out_res.head_value    = out_value_r;
  assign out_res.head_priority = out_prio_r;

  `SSPQ_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CAP_CNT, "entry count above capacity")
  `SSPQ_ASSERT_NOW(a_head_order, cnt_r > cnt_t'(1), prio_w[0] <= prio_w[1],
                   "head entry out of order")
  `SSPQ_ASSERT_NEXT(a_accept_pending, accept, pending_r,
                    "accepted request not held for result")
  `SSPQ_ASSERT_NOW(a_full_status, out_valid_r && out_status_r == ST_FULL,
                   out_total_r == CAP_CNT, "full status with free slots")
  `SSPQ_ASSERT_NEXT(a_load_result, out_load, out_valid_r && !pending_r,
                    "pending result not moved to output")

endmodule
